// ----- rtl/lc3s_pkg.sv -----
package lc3s_pkg;

    localparam int DEFAULT_MEMORY_WORDS = 32;
    localparam int NUM_REGS = 8;

    typedef logic [15:0] word_t;
    typedef logic [NUM_REGS-1:0][15:0] regfile_t;

    typedef enum logic [1:0] {
        CMD_LOAD_MEM = 2'd0,
        CMD_LOAD_REG = 2'd1,
        CMD_EXECUTE  = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // opcodes of the executed subset
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [7:0] HALT_VECTOR = 8'h25;

    localparam logic [2:0] FLAG_N = 3'b100;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_P = 3'b001;

    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  target;
        word_t       load_value;
    } item_t;

    typedef struct packed {
        word_t       pc;
        logic [2:0]  flags;
        logic        halted;
    } arch_state_t;

    typedef struct packed {
        arch_state_t state;
        word_t       ir;
        word_t       written;
        logic        reg_we;
        logic [2:0]  reg_idx;
        word_t       reg_data;
        logic        mem_we;
        word_t       mem_addr;
        word_t       mem_data;
        logic        ld_access;
        word_t       ld_addr;
    } exec_result_t;

    function automatic logic [2:0] flags_of(input word_t value);
        logic [2:0] f;
        if (value == 16'd0) begin
            f = FLAG_Z;
        end else if (value[15]) begin
            f = FLAG_N;
        end else begin
            f = FLAG_P;
        end
        return f;
    endfunction

endpackage

// ----- rtl/lc3_subset_instruction_step.sv -----
// flow: an item is taken into an input register, executed from it once the m_ side is free,
// and its result is registered onto the m_ side; an executed LD also waits for its operand
// throughput: one item per cycle while m_ready holds; an executed LD holds the input register
// until its operand arrives from the second registered read port of the main memory
// after the instruction word is known. reset: aresetn clears pc, flags (Z), halt and
// registers, then s_ready stays low while the main memory is cleared one word per cycle
module lc3_subset_instruction_step
    import lc3s_pkg::*;
#(
    parameter int MEMORY_WORDS = DEFAULT_MEMORY_WORDS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [4:0]  s_target_index,
    input  logic [15:0] s_load_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_program_counter,
    output logic [15:0] m_instruction_word,
    output logic [2:0]  m_flags_nzp,
    output logic [15:0] m_written_value,
    output logic        m_halted
);

    localparam int          ADDR_W    = $clog2(MEMORY_WORDS);
    localparam bit          WORDS_POW2 = (MEMORY_WORDS & (MEMORY_WORDS - 1)) == 0;
    // reciprocal for the word index when the memory size is not a power of two
    localparam logic [63:0] RECIP_64  = (64'd1 << 32) / MEMORY_WORDS;
    localparam logic [31:0] RECIP     = RECIP_64[31:0];
    localparam logic [33:0] WORDS_34  = 34'(MEMORY_WORDS);
    localparam logic [17:0] WORDS_18  = 18'(MEMORY_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEMORY_WORDS - 1);

    // address modulo memory size: mask, or reciprocal multiply with one correction
    function automatic logic [ADDR_W-1:0] word_index(input word_t addr);
        logic [47:0] prod;
        logic [15:0] quot;
        logic [33:0] back;
        logic [17:0] rem;
        prod = {32'd0, addr} * {16'd0, RECIP};
        quot = prod[47:32];
        back = {18'd0, quot} * WORDS_34;
        rem  = {2'b00, addr} - back[17:0];
        if (rem >= WORDS_18) begin
            rem = rem - WORDS_18;
        end
        if (WORDS_POW2) begin
            rem = {2'b00, addr};
        end
        return rem[ADDR_W-1:0];
    endfunction

    // architectural state
    arch_state_t state_reg;
    regfile_t    regs_reg;

    // input register
    logic        in_valid_reg;
    item_t       in_item_reg;

    // result register
    logic        m_valid_reg;
    word_t       m_pc_reg;
    word_t       m_ir_reg;
    logic [2:0]  m_flags_reg;
    word_t       m_written_reg;
    logic        m_halted_reg;

    // memory clearing after reset
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // set while an executed LD waits for its operand from the second read port
    logic ld_wait_reg;

    // fetch path: port A always reads the word at the next pc; a write to the same
    // word in that cycle is forwarded instead of the stale read data
    logic  bypass_hit_reg;
    word_t bypass_data_reg;

    exec_result_t      res;
    word_t             fetch_word;
    word_t             ram_a_data;
    word_t             ram_b_data;
    logic              out_free;
    logic              exec_fire;
    logic              in_take;
    word_t             pc_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    word_t             mem_wdata;
    logic [ADDR_W-1:0] fetch_addr;
    logic [ADDR_W-1:0] ld_addr;
    item_t             in_item_next;

    assign fetch_word = bypass_hit_reg ? bypass_data_reg : ram_a_data;

    lc3s_exec u_exec (
        .item       (in_item_reg),
        .state      (state_reg),
        .regs       (regs_reg),
        .fetch_word (fetch_word),
        .ld_data    (ram_b_data),
        .res        (res)
    );

    // an LD waits for its operand from the registered read port; everything else completes at once
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = in_valid_reg && out_free && (!res.ld_access || ld_wait_reg);
    assign s_ready   = !clear_busy_reg && (!in_valid_reg || exec_fire);
    assign in_take   = s_valid && s_ready;

    assign in_item_next.cmd        = cmd_t'(s_command);
    assign in_item_next.target     = s_target_index;
    assign in_item_next.load_value = s_load_value;

    assign pc_next = exec_fire ? res.state.pc : state_reg.pc;

    always_comb begin
        if (clear_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = 16'd0;
        end else begin
            mem_we    = exec_fire && res.mem_we;
            mem_waddr = word_index(res.mem_addr);
            mem_wdata = res.mem_data;
        end
        fetch_addr = word_index(pc_next);
        ld_addr    = word_index(res.ld_addr);
    end

    lc3s_ram #(
        .WIDTH (16),
        .DEPTH (MEMORY_WORDS)
    ) u_main_mem (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_a_addr (fetch_addr),
        .rd_a_data (ram_a_data),
        .rd_b_addr (ld_addr),
        .rd_b_data (ram_b_data)
    );

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pc     <= 16'd0;
            state_reg.flags  <= FLAG_Z;
            state_reg.halted <= 1'b0;
            regs_reg         <= '0;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            clear_busy_reg   <= 1'b1;
            clear_addr_reg   <= '0;
            ld_wait_reg      <= 1'b0;
            bypass_hit_reg   <= 1'b0;
        end else begin
            // clearing sweep, one word per cycle
            if (clear_busy_reg) begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == LAST_ADDR) begin
                    clear_busy_reg <= 1'b0;
                end
            end

            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (exec_fire) begin
                ld_wait_reg <= 1'b0;
            end else if (in_valid_reg && res.ld_access) begin
                ld_wait_reg <= 1'b1;
            end

            if (exec_fire) begin
                state_reg <= res.state;
                if (res.reg_we) begin
                    regs_reg[res.reg_idx] <= res.reg_data;
                end
            end

            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            bypass_hit_reg <= mem_we && (mem_waddr == fetch_addr);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= in_item_next;
        end
        if (exec_fire) begin
            m_pc_reg      <= res.state.pc;
            m_ir_reg      <= res.ir;
            m_flags_reg   <= res.state.flags;
            m_written_reg <= res.written;
            m_halted_reg  <= res.state.halted;
        end
        bypass_data_reg <= mem_wdata;
    end

    assign m_valid            = m_valid_reg;
    assign m_program_counter  = m_pc_reg;
    assign m_instruction_word = m_ir_reg;
    assign m_flags_nzp        = m_flags_reg;
    assign m_written_value    = m_written_reg;
    assign m_halted           = m_halted_reg;

endmodule

// ----- rtl/lc3s_ram.sv -----
module lc3s_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // read-first: a read in the cycle of a write returns the old word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_a_addr];
        rd_b_reg <= mem_reg[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ----- rtl/lc3s_exec.sv -----
module lc3s_exec
    import lc3s_pkg::*;
(
    input  item_t        item,
    input  arch_state_t  state,
    input  regfile_t     regs,
    input  word_t        fetch_word,
    input  word_t        ld_data,
    output exec_result_t res
);

    logic [3:0] opcode;
    logic [2:0] dr;
    logic [2:0] sr1;
    logic [2:0] sr2;
    word_t      off9;
    word_t      imm5;
    word_t      pc_inc;
    word_t      eff_addr;
    word_t      operand_a;
    word_t      operand_b;
    word_t      alu_value;

    always_comb begin
        opcode    = fetch_word[15:12];
        dr        = fetch_word[11:9];
        sr1       = fetch_word[8:6];
        sr2       = fetch_word[2:0];
        off9      = {{7{fetch_word[8]}}, fetch_word[8:0]};
        imm5      = {{11{fetch_word[4]}}, fetch_word[4:0]};
        pc_inc    = state.pc + 16'd1;
        eff_addr  = pc_inc + off9;
        operand_a = regs[sr1];
        operand_b = fetch_word[5] ? imm5 : regs[sr2];
        alu_value = (opcode == OP_ADD) ? (operand_a + operand_b) : (operand_a & operand_b);

        res           = '0;
        res.state     = state;
        res.reg_idx   = dr;
        res.mem_addr  = eff_addr;
        res.mem_data  = regs[dr];
        res.ld_addr   = eff_addr;

        unique case (item.cmd)
            CMD_LOAD_MEM: begin
                res.mem_we   = 1'b1;
                res.mem_addr = {11'd0, item.target};
                res.mem_data = item.load_value;
                res.written  = item.load_value;
            end
            CMD_LOAD_REG: begin
                res.reg_we   = 1'b1;
                res.reg_idx  = item.target[2:0];
                res.reg_data = item.load_value;
                res.written  = item.load_value;
            end
            CMD_EXECUTE: begin
                if (!state.halted) begin
                    res.ir       = fetch_word;
                    res.state.pc = pc_inc;
                    unique case (opcode)
                        OP_ADD, OP_AND: begin
                            res.reg_we      = 1'b1;
                            res.reg_data    = alu_value;
                            res.state.flags = flags_of(alu_value);
                            res.written     = alu_value;
                        end
                        OP_NOT: begin
                            res.reg_we      = 1'b1;
                            res.reg_data    = ~operand_a;
                            res.state.flags = flags_of(~operand_a);
                            res.written     = ~operand_a;
                        end
                        OP_BR: begin
                            if ((dr & state.flags) != 3'd0) begin
                                res.state.pc = eff_addr;
                            end
                        end
                        OP_JMP: begin
                            res.state.pc = operand_a;
                        end
                        OP_LD: begin
                            res.ld_access   = 1'b1;
                            res.reg_we      = 1'b1;
                            res.reg_data    = ld_data;
                            res.state.flags = flags_of(ld_data);
                            res.written     = ld_data;
                        end
                        OP_ST: begin
                            res.mem_we  = 1'b1;
                            res.written = regs[dr];
                        end
                        OP_TRAP: begin
                            if (fetch_word[7:0] == HALT_VECTOR) begin
                                res.state.halted = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule
